// ----- rtl/tcf_pkg.sv -----
// Package for the Telnet command filter: protocol byte codes, the parser
// state encoding and the result record shared by the parser and the top level.
// No dependencies.
package tcf_pkg;

   localparam logic [7:0] TN_SE   = 8'd240;
   localparam logic [7:0] TN_SB   = 8'd250;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_DONT = 8'd254;
   localparam logic [7:0] TN_IAC  = 8'd255;

   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   // Input item kinds carried on req_tuser.
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_IAC    = 3'd1,
      ST_OPT    = 3'd2,
      ST_SB     = 3'd3,
      ST_SB_IAC = 3'd4
   } parse_state_type;

   // One result word, without its last marker.
   typedef struct packed {
      logic       echo_on;
      logic [7:0] reply_option;
      logic [7:0] reply_verb;
      logic [7:0] data_byte;
      logic       reply_valid;
      logic       data_valid;
   } result_type;

endpackage

// ----- rtl/tcf_parser.sv -----
// Telnet IAC parser: holds the parse state, the pending verb and the echo flag,
// and turns one input item into its first result word. Depends on tcf_pkg.
module tcf_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,      // consume one item this cycle
   input  logic               op,
   input  logic [7:0]         rx_byte,
   output tcf_pkg::result_type res
);
   import tcf_pkg::*;

   parse_state_type state_ff, state_in;
   logic [7:0]      verb_ff, verb_in;
   logic            echo_ff, echo_in;
   logic            is_neg_verb;

   assign is_neg_verb = (rx_byte == TN_WILL) || (rx_byte == TN_WONT) ||
                        (rx_byte == TN_DO)   || (rx_byte == TN_DONT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      verb_in  = verb_ff;
      echo_in  = echo_ff;
      if (op == OP_START) begin
         state_in = ST_DATA;
         verb_in  = 8'd0;
         echo_in  = 1'b0;
      end else begin
         case (state_ff)
            ST_IAC: begin
               if (rx_byte == TN_IAC) begin
                  state_in = ST_DATA;
               end else if (is_neg_verb) begin
                  verb_in  = rx_byte;
                  state_in = ST_OPT;
               end else if (rx_byte == TN_SB) begin
                  state_in = ST_SB;
               end else begin
                  state_in = ST_DATA;
               end
            end
            ST_OPT: begin
               if (rx_byte == OPT_ECHO && (verb_ff == TN_DO || verb_ff == TN_DONT)) begin
                  echo_in = (verb_ff == TN_DO);
               end
               state_in = ST_DATA;
            end
            ST_SB: begin
               if (rx_byte == TN_IAC) begin
                  state_in = ST_SB_IAC;
               end
            end
            ST_SB_IAC: begin
               state_in = (rx_byte == TN_SE) ? ST_DATA : ST_SB;
            end
            default: begin
               state_in = (rx_byte == TN_IAC) ? ST_IAC : ST_DATA;
            end
         endcase
      end
   end

   // Result word.
   always_comb begin
      res         = '0;
      res.echo_on = echo_in;
      if (op == OP_START) begin
         res.reply_valid  = 1'b1;
         res.reply_verb   = TN_WILL;
         res.reply_option = OPT_ECHO;
      end else begin
         case (state_ff)
            ST_IAC: begin
               if (rx_byte == TN_IAC) begin
                  res.data_valid = 1'b1;
                  res.data_byte  = rx_byte;
               end
            end
            ST_OPT: begin
               if (rx_byte == OPT_ECHO && (verb_ff == TN_DO || verb_ff == TN_DONT)) begin
                  res.reply_valid = 1'b0;
               end else if (verb_ff == TN_DO && rx_byte != OPT_SGA) begin
                  res.reply_valid  = 1'b1;
                  res.reply_verb   = TN_WONT;
                  res.reply_option = rx_byte;
               end else if (verb_ff == TN_WILL) begin
                  res.reply_valid  = 1'b1;
                  res.reply_verb   = TN_DONT;
                  res.reply_option = rx_byte;
               end
            end
            ST_SB, ST_SB_IAC: begin
               res.data_valid = 1'b0;
            end
            default: begin
               if (rx_byte != TN_IAC) begin
                  res.data_valid = 1'b1;
                  res.data_byte  = rx_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         verb_ff  <= 8'd0;
         echo_ff  <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         verb_ff  <= verb_in;
         echo_ff  <= echo_in;
      end
   end

endmodule

// ----- rtl/telnet_command_filter.sv -----
// Top level of the Telnet command filter: input register, parser and result
// register with the second word of a session start. Depends on tcf_pkg and
// tcf_parser.

// The filter takes one received Telnet byte per word on the req_ stream and
// hands every byte one result word on the rsp_ stream, with rsp_tlast set.
// A session start item (req_tuser high) resets the parser, clears echo and
// yields two words, WILL ECHO and then WILL SGA, the second marked by
// rsp_tlast. Received bytes go at one per clock cycle with no bubbles while
// rsp_tready stays high; a session start occupies the result register for
// both of its words, so the item after it waits. The accepting edge loads
// the input register, and the item then moves through the parser into the
// result register once that register is free, so the first result word
// shows on rsp_ from the result register. The parse state advances as an
// item moves from the input register into the result register, so the
// input register can still take one more word while a finished word waits
// on rsp_tready.
module telnet_command_filter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] op: 0 received byte, 1 session start

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] reply_verb,
                                    // [23:16] reply_option, [24] echo_on, rest zero
   output logic [1:0]  rsp_tuser,   // [0] data_valid, [1] reply_valid
   output logic        rsp_tlast    // last word caused by the input item
);
   import tcf_pkg::*;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_byte_ff;

   // Result register and the pending second word of a session start.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       second_ff, second_in;
   result_type rsp_res_ff, rsp_res_in;
   logic       rsp_last_ff, rsp_last_in;

   result_type parse_res;
   result_type sga_res;
   logic       out_free;
   logic       s1_fire;
   logic       req_fire;

   // The result register can take a new word when it is empty, or when its
   // word leaves this cycle and no second session-start word is still owed.
   assign out_free   = !rsp_valid_ff || (rsp_tready && !second_ff);
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   tcf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_fire),
      .op      (s1_op_ff),
      .rx_byte (s1_byte_ff),
      .res     (parse_res)
   );

   // Second word of a session start: WILL SGA with echo off.
   always_comb begin
      sga_res              = '0;
      sga_res.reply_valid  = 1'b1;
      sga_res.reply_verb   = TN_WILL;
      sga_res.reply_option = OPT_SGA;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      second_in    = second_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         second_in    = (s1_op_ff == OP_START);
         rsp_res_in   = parse_res;
         rsp_last_in  = (s1_op_ff != OP_START);
      end else if (second_ff && rsp_tready) begin
         second_in    = 1'b0;
         rsp_res_in   = sga_res;
         rsp_last_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_res_ff.echo_on, rsp_res_ff.reply_option,
                        rsp_res_ff.reply_verb, rsp_res_ff.data_byte};
   assign rsp_tuser  = {rsp_res_ff.reply_valid, rsp_res_ff.data_valid};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // A second session-start word is only owed while the first one is shown.
   a_second_has_word: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> rsp_tvalid)
      else $error("second word pending without a visible result word");

   // Only the first word of a session start goes out without tlast.
   a_nonlast_is_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (second_ff && rsp_tuser[1] &&
                                      rsp_tdata[23:16] == OPT_ECHO))
      else $error("word without tlast is not the WILL ECHO offer");

   // Taking the first offer word brings up WILL SGA with tlast next cycle.
   a_sga_follows: assert property (@(posedge clock) disable iff (reset)
      (second_ff && rsp_tready) |=> (rsp_tvalid && rsp_tlast &&
                                     rsp_tdata[23:16] == OPT_SGA &&
                                     rsp_tdata[15:8] == TN_WILL))
      else $error("WILL SGA did not follow WILL ECHO");

   // A session start always leaves echo off in its first word.
   a_start_clears_echo: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_op_ff == OP_START) |=> (rsp_tvalid && !rsp_tdata[24]))
      else $error("session start left echo on");

   // No new item enters the result register while the offer is unfinished.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !s1_fire)
      else $error("result register overwritten during session start");
`endif

endmodule
